// File: hw/rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants, types and helpers of the per-group top-ten tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  // sizing
  localparam int NUM_GROUPS = 10;
  localparam int TOP_K      = 10;

  // fixed field widths
  localparam int GROUP_W = 4;
  localparam int RANK_OW = 4;
  localparam int VALUE_W = 32;

  // derived internal widths
  localparam int RANK_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CNT_W  = $clog2(TOP_K + 1);
  localparam int DEPTH  = NUM_GROUPS * TOP_K;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // opcodes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  typedef logic [GROUP_W-1:0]        group_t;
  typedef logic [RANK_OW-1:0]        rank_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RANK_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_EVCHK,
    ST_PLACE,
    ST_EMPTY,
    ST_RDOUT
  } state_t;

  // value memory access from the sequencer
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    logic   re;
    addr_t  raddr;
  } ram_req_t;

  // count file write
  typedef struct packed {
    logic   we;
    group_t grp;
    cnt_t   cnt;
  } cnt_wr_t;

  // slot of rank r in group g
  function automatic addr_t row_addr(input group_t g, input idx_t r);
    row_addr = ADDR_W'(g) * ADDR_W'(TOP_K) + ADDR_W'(r);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ptt_if.sv
// ----------------------------------------------------------------------------
// ptt_if
// Request and result channels of the tracker, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptt_req_if import ptt_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  group_t group_id;
  value_t item_value;

  modport source (output valid, opcode, group_id, item_value, input ready);
  modport sink   (input valid, opcode, group_id, item_value, output ready);
endinterface

interface ptt_res_if import ptt_pkg::*; ();
  logic   valid;
  logic   ready;
  group_t out_group;
  rank_t  out_rank;
  value_t out_value;
  logic   out_valid;
  logic   out_last;

  modport source (output valid, out_group, out_rank, out_value, out_valid, out_last,
                  input ready);
  modport sink   (input valid, out_group, out_rank, out_value, out_valid, out_last,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ptt_value_ram.sv
// ----------------------------------------------------------------------------
// ptt_value_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_value_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                        wdata,
  input  wire                                     re,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptt_count_file.sv
// ----------------------------------------------------------------------------
// ptt_count_file
// Per-group fill counts, cleared at reset, one read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_count_file import ptt_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  group_t  rd_grp,
  output cnt_t    rd_cnt,
  input  cnt_wr_t wr
);

  cnt_t counts [NUM_GROUPS];

  // write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        counts[i] <= '0;
      end
    end else if (wr.we) begin
      counts[wr.grp] <= wr.cnt;
    end
  end

  // read port, groups out of range read as empty
  always_comb begin
    if (32'(rd_grp) < NUM_GROUPS) begin
      rd_cnt = counts[rd_grp];
    end else begin
      rd_cnt = '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptt_seq.sv
// ----------------------------------------------------------------------------
// ptt_seq
// Request sequencer: sorted insert walk, eviction walk and readout over the
// value memory, with the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_seq import ptt_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  ptt_req_if.sink      req,
  ptt_res_if.source    res,
  output group_t       cnt_rd_grp,
  input  cnt_t         cnt_rd,
  output cnt_wr_t      cnt_wr,
  output ram_req_t     ram_req,
  input  value_t       ram_rdata
);

  state_t state, state_next;

  // request context
  group_t grp, grp_next;
  value_t val, val_next;
  idx_t   pos, pos_next;
  idx_t   last_rank, last_rank_next;
  logic   dir_up, dir_up_next;

  // output register
  logic   o_valid;
  rank_t  o_rank;
  value_t o_value;
  logic   o_vld;
  logic   o_last;
  group_t o_group;

  logic   out_load;
  rank_t  ld_rank;
  value_t ld_value;
  logic   ld_vld;
  logic   ld_last;

  logic   accept;
  logic   grp_ok;
  logic   in_full;
  logic   in_empty;
  cnt_t   cnt_m1;
  logic   walk_shift;
  idx_t   walk_pos;
  logic   walk_end;
  logic   evict_take;
  logic   evict_end;
  logic   rd_last;
  logic   slot_free;

  // decode helpers
  assign cnt_rd_grp = req.group_id;
  assign accept     = req.valid && req.ready;
  assign grp_ok     = 32'(req.group_id) < NUM_GROUPS;
  assign in_full    = cnt_rd == CNT_W'(TOP_K);
  assign in_empty   = cnt_rd == '0;
  assign cnt_m1     = cnt_rd - CNT_W'(1);

  // walk: entries move toward the hole while they lie on the wrong side of val
  assign walk_shift = dir_up ? (ram_rdata > val) : (ram_rdata < val);
  assign walk_pos   = dir_up ? (pos - RANK_W'(1)) : (pos + RANK_W'(1));
  assign walk_end   = dir_up ? (walk_pos == '0) : (walk_pos == RANK_W'(TOP_K - 1));
  assign evict_take = val > ram_rdata;
  assign evict_end  = RANK_W'(TOP_K - 1) == '0;
  assign rd_last    = pos == last_rank;
  assign slot_free  = !o_valid || res.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.opcode == OP_INSERT) begin
            if (!grp_ok) begin
              state_next = ST_IDLE;
            end else if (in_full) begin
              state_next = ST_EVCHK;
            end else if (in_empty) begin
              state_next = ST_PLACE;
            end else begin
              state_next = ST_WALK;
            end
          end else begin
            state_next = (!grp_ok || in_empty) ? ST_EMPTY : ST_RDOUT;
          end
        end
      end
      ST_WALK: begin
        if (walk_shift) begin
          state_next = walk_end ? ST_PLACE : ST_WALK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVCHK: begin
        if (!evict_take) begin
          state_next = ST_IDLE;
        end else begin
          state_next = evict_end ? ST_PLACE : ST_WALK;
        end
      end
      ST_PLACE: state_next = ST_IDLE;
      ST_EMPTY: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        if (slot_free && rd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and context updates
  always_comb begin
    req.ready      = 1'b0;
    ram_req        = '0;
    cnt_wr         = '0;
    out_load       = 1'b0;
    ld_rank        = '0;
    ld_value       = '0;
    ld_vld         = 1'b0;
    ld_last        = 1'b0;
    grp_next       = grp;
    val_next       = val;
    pos_next       = pos;
    last_rank_next = last_rank;
    dir_up_next    = dir_up;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (accept) begin
          grp_next = req.group_id;
          val_next = req.item_value;
          if (req.opcode == OP_INSERT) begin
            if (grp_ok && !in_full) begin
              // open a hole at the end of the list and walk it down
              cnt_wr.we   = 1'b1;
              cnt_wr.grp  = req.group_id;
              cnt_wr.cnt  = cnt_rd + CNT_W'(1);
              pos_next    = cnt_rd[RANK_W-1:0];
              dir_up_next = 1'b1;
              if (!in_empty) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = row_addr(req.group_id, cnt_m1[RANK_W-1:0]);
              end
            end else if (grp_ok) begin
              // full: fetch the smallest entry first
              ram_req.re    = 1'b1;
              ram_req.raddr = row_addr(req.group_id, '0);
            end
          end else begin
            pos_next       = '0;
            last_rank_next = cnt_m1[RANK_W-1:0];
            if (grp_ok && !in_empty) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = row_addr(req.group_id, '0);
            end
          end
        end
      end
      ST_WALK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = row_addr(grp, pos);
        if (walk_shift) begin
          ram_req.wdata = ram_rdata;
          pos_next      = walk_pos;
          if (!walk_end) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = row_addr(grp, dir_up ? (walk_pos - RANK_W'(1))
                                                 : (walk_pos + RANK_W'(1)));
          end
        end else begin
          ram_req.wdata = val;
        end
      end
      ST_EVCHK: begin
        // smallest evicted: hole at rank 0, walk upward
        pos_next    = '0;
        dir_up_next = 1'b0;
        if (evict_take && !evict_end) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = row_addr(grp, RANK_W'(1));
        end
      end
      ST_PLACE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = row_addr(grp, pos);
        ram_req.wdata = val;
      end
      ST_EMPTY: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
        end
      end
      ST_RDOUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_rank  = RANK_OW'(pos);
          ld_value = ram_rdata;
          ld_vld   = 1'b1;
          ld_last  = rd_last;
          if (!rd_last) begin
            pos_next      = pos + RANK_W'(1);
            ram_req.re    = 1'b1;
            ram_req.raddr = row_addr(grp, pos + RANK_W'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    grp       <= grp_next;
    val       <= val_next;
    pos       <= pos_next;
    last_rank <= last_rank_next;
    dir_up    <= dir_up_next;
    if (out_load) begin
      o_group <= grp;
      o_rank  <= ld_rank;
      o_value <= ld_value;
      o_vld   <= ld_vld;
      o_last  <= ld_last;
    end
  end

  assign res.valid     = o_valid;
  assign res.out_group = o_group;
  assign res.out_rank  = o_rank;
  assign res.out_value = o_value;
  assign res.out_valid = o_vld;
  assign res.out_last  = o_last;

endmodule

`default_nettype wire

// File: hw/rtl/per_group_top_ten_tracker.sv
// ----------------------------------------------------------------------------
// per_group_top_ten_tracker
// Keeps the ten largest values of each group in sorted order and reads
// a group out in ascending order on request.
// ----------------------------------------------------------------------------
// Insert: an out-of-range request is dropped, as is a value no larger than the
//   smallest entry of a full group; otherwise one list entry moves per cycle.
// Readout: the first result passes the memory read and output registers, then
//   one per cycle while the sink is ready; an empty group gives one result.
// One request is in flight at a time; the next is taken once the last is done.
// Reset clears the fill counts at once; the value memory is not cleared.
`default_nettype none

module per_group_top_ten_tracker import ptt_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  ptt_req_if.sink   req,
  ptt_res_if.source res
);

  ram_req_t ram_req;
  value_t   ram_rdata;
  cnt_wr_t  cnt_wr;
  group_t   cnt_rd_grp;
  cnt_t     cnt_rd;

  // request sequencer
  ptt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res        (res),
    .cnt_rd_grp (cnt_rd_grp),
    .cnt_rd     (cnt_rd),
    .cnt_wr     (cnt_wr),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  // fill counts
  ptt_count_file u_count (
    .clk    (clk),
    .rst    (rst),
    .rd_grp (cnt_rd_grp),
    .rd_cnt (cnt_rd),
    .wr     (cnt_wr)
  );

  // sorted value lists
  ptt_value_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // the walk never reads the slot it writes in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
    else $error("value memory read and write hit the same slot");

  // a count update stays within one to TOP_K
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt_wr.we |-> (cnt_wr.cnt != '0) && (32'(cnt_wr.cnt) <= TOP_K))
    else $error("fill count out of range");

  // an empty-group result is rank 0, value 0 and closes the run
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.out_valid |-> res.out_last && (res.out_rank == '0)
                                    && (res.out_value == '0))
    else $error("malformed empty-group result");

  // reported ranks stay below TOP_K
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.out_valid |-> 32'(res.out_rank) < TOP_K)
    else $error("reported rank out of range");

endmodule

`default_nettype wire
